// ===== hw/rtl/radial_alpha_falloff_macros.svh =====
// Assertion macros shared by the radial alpha falloff RTL.
`ifndef RADIAL_ALPHA_FALLOFF_MACROS_SVH
`define RADIAL_ALPHA_FALLOFF_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rdaf_pkg.sv =====
// Shared constants, widths and payload types of the radial alpha falloff block.
package rdaf_pkg;

  localparam int MAX_SIZE = 1024;

  // Fixed field widths
  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;
  localparam int ALPHA_W = 8;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

  // Stream packing
  localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ALPHA_W + 7) / 8) * 8;

  // Geometry widths (doubled coordinates)
  localparam int SIZE_W = $clog2(MAX_SIZE) + 1;
  localparam int TWO_W  = (SIZE_W > COORD_W + 1) ? SIZE_W : COORD_W + 1;
  localparam int SQ_W   = 2 * SIZE_W - 1;
  localparam int DEN_W  = 2 * SIZE_W;
  localparam int REM_W  = DEN_W + 1;

  // Ratio quotient: Q0.32 plus one integer bit
  localparam int R2_FRAC    = 32;
  localparam int R2_W       = R2_FRAC + 1;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = R2_FRAC / DIV_STEP;

  // Square root in Q0.16, value range 0..2^16
  localparam int ROOT_FRAC = R2_FRAC / 2;
  localparam int ROOT_W    = ROOT_FRAC + 1;
  localparam int SQ_REM_W  = R2_W + 2;

  localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1) << ROOT_FRAC;

  localparam int SCALE_W = 8;
  localparam logic [SCALE_W-1:0] ALPHA_SCALE = SCALE_W'(255);

  // Output skid buffer
  localparam int SKID_DEPTH = 2;
  localparam int SKID_PTR_W = $clog2(SKID_DEPTH);
  localparam int SKID_CNT_W = $clog2(SKID_DEPTH + 1);

  typedef struct packed {
    logic [DEN_W-1:0] d2;
    logic [DEN_W-1:0] den;
    logic             outside;
  } div_in_t;

  typedef struct packed {
    logic [R2_W-1:0] r2;
    logic            outside;
  } div_out_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              outside;
  } root_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               outside;
  } out_item_t;

endpackage

// ===== hw/rtl/rdaf_div.sv =====
// Pipelined restoring divider: squared distance over squared half-diagonal, Q0.32.
module rdaf_div import rdaf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     ce,
  input  logic     in_vld,
  input  div_in_t  in_item,
  output logic     out_vld,
  output div_out_t out_item
);

  localparam int NST = DIV_STAGES + 1;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [R2_W-1:0]  q;
  } div_acc_t;

  function automatic div_acc_t div_step(input div_acc_t acc, input logic [DEN_W-1:0] den);
    div_acc_t         res;
    logic [REM_W-1:0] den_ext;
    res     = acc;
    den_ext = REM_W'(den);
    for (int j = 0; j < DIV_STEP; j++) begin
      res.rem = {res.rem[REM_W-2:0], 1'b0};
      if (res.rem >= den_ext) begin
        res.rem = res.rem - den_ext;
        res.q   = {res.q[R2_W-2:0], 1'b1};
      end else begin
        res.q   = {res.q[R2_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   outside_r;
  logic [R2_W-1:0]  q_r   [NST];
  logic [REM_W-1:0] rem_r [NST-1];
  logic [DEN_W-1:0] den_r [NST-1];

  logic [REM_W-1:0] rem0_nxt;
  logic [R2_W-1:0]  q0_nxt;

  // integer bit: set only when the distance reaches the half-diagonal
  always_comb begin
    rem0_nxt = REM_W'(in_item.d2);
    q0_nxt   = '0;
    if (in_item.d2 >= in_item.den) begin
      rem0_nxt = REM_W'(in_item.d2 - in_item.den);
      q0_nxt   = R2_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q_r[0]       <= q0_nxt;
      rem_r[0]     <= rem0_nxt;
      den_r[0]     <= in_item.den;
      outside_r[0] <= in_item.outside | (in_item.d2 > in_item.den);
    end
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    div_acc_t acc_in;
    div_acc_t acc_nxt;

    assign acc_in  = '{rem: rem_r[g-1], q: q_r[g-1]};
    assign acc_nxt = div_step(acc_in, den_r[g-1]);

    always_ff @(posedge clk) begin
      if (ce) begin
        q_r[g]       <= acc_nxt.q;
        outside_r[g] <= outside_r[g-1];
      end
    end

    if (g < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[g] <= acc_nxt.rem;
          den_r[g] <= den_r[g-1];
        end
      end
    end
  end

  assign out_vld          = vld_r[NST-1];
  assign out_item.r2      = q_r[NST-1];
  assign out_item.outside = outside_r[NST-1];

endmodule

// ===== hw/rtl/rdaf_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
module rdaf_sqrt import rdaf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ce,
  input  logic       in_vld,
  input  div_out_t   in_item,
  output logic       out_vld,
  output root_item_t out_item
);

  localparam int NST = ROOT_W;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_acc_t;

  // rem holds v - root^2; trial is (root + 2^b)^2 - root^2
  function automatic sq_acc_t sqrt_step(input sq_acc_t acc, input int b);
    sq_acc_t             res;
    logic [SQ_REM_W-1:0] trial;
    res   = acc;
    trial = (SQ_REM_W'(acc.root) << (b + 1)) | (SQ_REM_W'(1) << (2 * b));
    if (acc.rem >= trial) begin
      res.rem  = acc.rem - trial;
      res.root = acc.root | (ROOT_W'(1) << b);
    end
    return res;
  endfunction

  logic [NST-1:0]      vld_r;
  logic [NST-1:0]      outside_r;
  logic [ROOT_W-1:0]   root_r [NST];
  logic [SQ_REM_W-1:0] rem_r  [NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  for (genvar g = 0; g < NST; g++) begin : g_stage
    sq_acc_t acc_in;
    sq_acc_t acc_nxt;

    if (g == 0) begin : g_first
      assign acc_in = '{rem: SQ_REM_W'(in_item.r2), root: '0};
      always_ff @(posedge clk) begin
        if (ce) begin
          outside_r[g] <= in_item.outside;
        end
      end
    end else begin : g_next
      assign acc_in = '{rem: rem_r[g-1], root: root_r[g-1]};
      always_ff @(posedge clk) begin
        if (ce) begin
          outside_r[g] <= outside_r[g-1];
        end
      end
    end

    assign acc_nxt = sqrt_step(acc_in, NST - 1 - g);

    always_ff @(posedge clk) begin
      if (ce) begin
        root_r[g] <= acc_nxt.root;
      end
    end

    if (g < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[g] <= acc_nxt.rem;
        end
      end
    end
  end

  assign out_vld          = vld_r[NST-1];
  assign out_item.root    = root_r[NST-1];
  assign out_item.outside = outside_r[NST-1];

endmodule

// ===== hw/rtl/rdaf_pow.sv =====
// Falloff shaping: (1 - r)^4 in Q0.16, scaled to a byte; one subtract stage, then one multiply per stage.
module rdaf_pow import rdaf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ce,
  input  logic       in_vld,
  input  root_item_t in_item,
  output logic       out_vld,
  output out_item_t  out_item
);

  localparam int NST    = 4;
  localparam int PROD_W = 2 * ROOT_W;
  localparam int SCL_W  = ROOT_W + SCALE_W;

  logic [NST-1:0]     vld_r;
  logic [NST-1:0]     outside_r;
  logic [ROOT_W-1:0]  a_r, a2_r, a4_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic [PROD_W-1:0]  a2_prod, a4_prod;
  logic [SCL_W-1:0]   scl_prod;

  assign a2_prod  = PROD_W'(a_r) * PROD_W'(a_r);
  assign a4_prod  = PROD_W'(a2_r) * PROD_W'(a2_r);
  assign scl_prod = SCL_W'(a4_r) * SCL_W'(ALPHA_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_r       <= ROOT_ONE - in_item.root;
      a2_r      <= a2_prod[ROOT_FRAC +: ROOT_W];
      a4_r      <= a4_prod[ROOT_FRAC +: ROOT_W];
      alpha_r   <= outside_r[2] ? '0 : scl_prod[ROOT_FRAC +: ALPHA_W];
      outside_r <= {outside_r[NST-2:0], in_item.outside};
    end
  end

  assign out_vld          = vld_r[NST-1];
  assign out_item.alpha   = alpha_r;
  assign out_item.outside = outside_r[NST-1];

endmodule

// ===== hw/rtl/rdaf_skid.sv =====
// Two-entry output buffer that decouples the pipeline from the result consumer.
module rdaf_skid import rdaf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t             mem_r [SKID_DEPTH];
  logic [SKID_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [SKID_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  function automatic logic [SKID_PTR_W-1:0] ptr_inc(input logic [SKID_PTR_W-1:0] p);
    return (p == SKID_PTR_W'(SKID_DEPTH - 1)) ? '0 : p + SKID_PTR_W'(1);
  endfunction

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == SKID_CNT_W'(SKID_DEPTH));
  assign out_item  = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + SKID_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - SKID_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/radial_alpha_falloff.sv =====
// Path from an input transaction to its earliest result transaction: 3 geometry,
// 17 divider, 17 square-root and 4 shaping stages, then the output buffer register.
// Throughput: one coordinate pair per cycle; every stage is a register stage fed at
// full rate, and the pipeline halts only while the two-entry output buffer is full.
// Reset (synchronous, rst_n low): all valid bits and the output buffer are cleared,
// texture_size returns to 64.
module radial_alpha_falloff import rdaf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: texture_size write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] pixel_x, [19:10] pixel_y, rest zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] alpha_value
  output logic [0:0]             out_tuser   // [0] outside_flag
);

`include "radial_alpha_falloff_macros.svh"

  // ---------------------------------------------------------------------------
  // Configuration: texture side length, saturated to MAX_SIZE on use.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  size_r;
  logic [SIZE_W-1:0] size_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  assign size_eff = (32'(size_r) > 32'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : SIZE_W'(size_r);

  // ---------------------------------------------------------------------------
  // Pipeline enable: every stage moves together. The output buffer keeps a free
  // slot for the item in the last stage, so the enable depends only on its count.
  // ---------------------------------------------------------------------------
  logic ce;
  logic skid_full;

  assign ce        = !skid_full;
  assign in_tready = ce;

  // ---------------------------------------------------------------------------
  // Geometry stages: doubled-coordinate offsets from the centre, range check, squares and sums.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] px, py;
  logic [TWO_W-1:0]   two_x, two_y, s_ext;
  logic [TWO_W-1:0]   dx_full, dy_full;
  logic               outside_f1;

  assign px    = in_tdata[COORD_W-1:0];
  assign py    = in_tdata[2*COORD_W-1:COORD_W];
  assign two_x = TWO_W'({px, 1'b0});
  assign two_y = TWO_W'({py, 1'b0});
  assign s_ext = TWO_W'(size_eff);

  assign dx_full = (two_x >= s_ext) ? (two_x - s_ext) : (s_ext - two_x);
  assign dy_full = (two_y >= s_ext) ? (two_y - s_ext) : (s_ext - two_y);

  // zero size makes every pixel fall outside
  assign outside_f1 = (size_eff == '0) || (TWO_W'(px) >= s_ext) || (TWO_W'(py) >= s_ext);

  logic [2:0]        geo_vld_r;
  logic [2:0]        geo_out_r;
  logic [SIZE_W-1:0] dx_r, dy_r, s_r;
  logic [SQ_W-1:0]   dx2_r, dy2_r, s2_r;
  logic [DEN_W-1:0]  d2_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_vld_r <= '0;
    end else if (ce) begin
      geo_vld_r <= {geo_vld_r[1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // stage 1: offsets (at most the side length inside the texture)
      dx_r      <= dx_full[SIZE_W-1:0];
      dy_r      <= dy_full[SIZE_W-1:0];
      s_r       <= size_eff;
      // stage 2: squares
      dx2_r     <= SQ_W'(dx_r) * SQ_W'(dx_r);
      dy2_r     <= SQ_W'(dy_r) * SQ_W'(dy_r);
      s2_r      <= SQ_W'(s_r) * SQ_W'(s_r);
      // stage 3: squared distance and squared half-diagonal, both doubled units
      d2_r      <= DEN_W'(dx2_r) + DEN_W'(dy2_r);
      den_r     <= {s2_r, 1'b0};
      geo_out_r <= {geo_out_r[1:0], outside_f1};
    end
  end

  // ---------------------------------------------------------------------------
  // Ratio, root and shaping pipelines.
  // ---------------------------------------------------------------------------
  div_in_t    div_in;
  div_out_t   div_out;
  root_item_t root_out;
  out_item_t  pow_out;
  out_item_t  skid_out;
  logic       div_vld, root_vld, pow_vld;

  assign div_in = '{d2: d2_r, den: den_r, outside: geo_out_r[2]};

  rdaf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (geo_vld_r[2]),
    .in_item  (div_in),
    .out_vld  (div_vld),
    .out_item (div_out)
  );

  rdaf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (div_vld),
    .in_item  (div_out),
    .out_vld  (root_vld),
    .out_item (root_out)
  );

  rdaf_pow u_pow (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (root_vld),
    .in_item  (root_out),
    .out_vld  (pow_vld),
    .out_item (pow_out)
  );

  // ---------------------------------------------------------------------------
  // Output buffer: takes the last stage's valid item on every enabled cycle.
  // ---------------------------------------------------------------------------
  rdaf_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ce & pow_vld),
    .push_item (pow_out),
    .full      (skid_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (skid_out)
  );

  assign out_tdata    = OUT_TDATA_W'(skid_out.alpha);
  assign out_tuser[0] = skid_out.outside;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // input is held back only while results are waiting
  `RDAF_ASSERT_NOW(a_stall_has_result, clk, rst_n, !in_tready, out_tvalid,
                   "input stalled with no pending result")
  // a full buffer that is not drained stays full
  `RDAF_ASSERT_NEXT(a_full_holds, clk, rst_n, !in_tready && !out_tready, !in_tready,
                    "output buffer lost an entry while stalled")
  // pixels flagged outside carry zero alpha
  `RDAF_ASSERT_NOW(a_outside_zero, clk, rst_n, out_tvalid && out_tuser[0],
                   out_tdata[ALPHA_W-1:0] == '0,
                   "outside pixel with nonzero alpha")

endmodule
